// File: hdl/gbrbe_pkg.sv
// Package for the GenBank record base extractor: word types, codes and character tables.
`timescale 1ns / 1ps

package gbrbe_pkg;

   // Longest record name that is forwarded, and the counter width it needs
   localparam int NAME_LIMIT   = 256;
   localparam int NAME_LEN_W   = $clog2(NAME_LIMIT + 1);

   localparam logic [3:0] NAME_COLUMN = 4'd12;
   localparam logic [3:0] HDR_LEN     = 4'd5;
   localparam logic [3:0] ORG_LEN     = 4'd6;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam logic [7:0] AMBIG_CODE = 8'd10;
   localparam logic [7:0] NO_BASE    = 8'd255;

   // Result kinds
   localparam logic [2:0] KIND_NAME     = 3'd0;
   localparam logic [2:0] KIND_BASE     = 3'd1;
   localparam logic [2:0] KIND_DONE     = 3'd2;
   localparam logic [2:0] KIND_NOMORE   = 3'd3;
   localparam logic [2:0] KIND_HDRERR   = 3'd4;
   localparam logic [2:0] KIND_NOORIGIN = 3'd5;

   typedef enum logic [2:0] {
      PH_HDR,
      PH_NAME,
      PH_SKIPLINE,
      PH_SEEK_ORIGIN,
      PH_ORIGIN_LINE,
      PH_SEQ,
      PH_TRAILER,
      PH_HALT
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  value;
      logic [31:0] base_count;
   } rsp_word_type;

   // Letters of the record header keyword
   function automatic logic [7:0] hdr_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h4C; // L
         3'd1:    c = 8'h4F; // O
         3'd2:    c = 8'h43; // C
         3'd3:    c = 8'h55; // U
         3'd4:    c = 8'h53; // S
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Letters of the sequence start keyword
   function automatic logic [7:0] org_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h4F; // O
         3'd1:    c = 8'h52; // R
         3'd2:    c = 8'h49; // I
         3'd3:    c = 8'h47; // G
         3'd4:    c = 8'h49; // I
         3'd5:    c = 8'h4E; // N
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Map a base or ambiguity letter of either case to its base code, anything else to NO_BASE
   function automatic logic [7:0] base_code(input logic [7:0] b);
      logic [7:0] c;
      logic [7:0] code;
      if (b >= 8'h41 && b <= 8'h5A) begin
         c = b + 8'd32;
      end else begin
         c = b;
      end
      unique case (c)
         8'h74, 8'h75: code = 8'd0;        // t u
         8'h63:        code = 8'd1;        // c
         8'h61:        code = 8'd2;        // a
         8'h67:        code = 8'd3;        // g
         8'h79, 8'h72, 8'h73, 8'h77, 8'h6B, 8'h6D, 8'h62,
         8'h64, 8'h68, 8'h69, 8'h71, 8'h76, 8'h78, 8'h6E:
                       code = AMBIG_CODE;  // ambiguity letters
         default:      code = NO_BASE;
      endcase
      return code;
   endfunction

endpackage

// File: hdl/gbrbe_parser.sv
// Parser state registers and the per-byte next-state and result logic.
`timescale 1ns / 1ps

module gbrbe_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  gbrbe_pkg::req_word_type word,
   input  logic                  count_only,
   output logic                  res_valid,
   output gbrbe_pkg::rsp_word_type res_word
);

   gbrbe_pkg::phase_type            phase_ff, phase_in;
   logic [3:0]                      column_ff, column_in;
   logic                            prefix_ff, prefix_in;
   logic [gbrbe_pkg::NAME_LEN_W-1:0] name_len_ff, name_len_in;
   logic [31:0]                     bases_ff, bases_in;
   logic [1:0]                      trailer_ff, trailer_in;

   logic [7:0] b;
   logic [7:0] code;
   logic [3:0] column_inc;
   logic       prefix_next;

   assign b          = word.text_byte;
   assign code       = gbrbe_pkg::base_code(b);
   assign column_inc = column_ff + 4'd1;

   // Compute next state and the result for one byte
   always_comb begin
      phase_in    = phase_ff;
      column_in   = column_ff;
      prefix_in   = prefix_ff;
      name_len_in = name_len_ff;
      bases_in    = bases_ff;
      trailer_in  = trailer_ff;
      res_valid   = 1'b0;
      res_word    = '0;
      prefix_next = prefix_ff;

      if (phase_ff == gbrbe_pkg::PH_HALT) begin
         // halted: drop everything until reset
      end else if (word.end_of_text) begin
         unique case (phase_ff)
            gbrbe_pkg::PH_HDR: begin
               phase_in  = gbrbe_pkg::PH_HALT;
               res_valid = 1'b1;
               if (column_ff == 4'd0) begin
                  res_word.kind = gbrbe_pkg::KIND_NOMORE;
               end else if (column_ff < gbrbe_pkg::HDR_LEN) begin
                  res_word.kind = gbrbe_pkg::KIND_HDRERR;
               end else begin
                  res_word.kind = gbrbe_pkg::KIND_NOORIGIN;
               end
            end
            gbrbe_pkg::PH_NAME, gbrbe_pkg::PH_SKIPLINE, gbrbe_pkg::PH_SEEK_ORIGIN: begin
               phase_in      = gbrbe_pkg::PH_HALT;
               res_valid     = 1'b1;
               res_word.kind = gbrbe_pkg::KIND_NOORIGIN;
            end
            gbrbe_pkg::PH_ORIGIN_LINE, gbrbe_pkg::PH_SEQ: begin
               res_valid           = 1'b1;
               res_word.kind       = gbrbe_pkg::KIND_DONE;
               res_word.base_count = bases_ff;
               phase_in            = gbrbe_pkg::PH_HDR;
               column_in           = 4'd0;
               prefix_in           = 1'b1;
               name_len_in         = '0;
               bases_in            = '0;
               trailer_in          = 2'd0;
            end
            default: begin
               phase_in      = gbrbe_pkg::PH_HALT;
               res_valid     = 1'b1;
               res_word.kind = gbrbe_pkg::KIND_NOMORE;
            end
         endcase
      end else begin
         unique case (phase_ff)
            gbrbe_pkg::PH_HDR: begin
               if (b == gbrbe_pkg::CHAR_LF) begin
                  if (column_ff == 4'd0) begin
                     // empty line: skip
                  end else if (column_ff < gbrbe_pkg::HDR_LEN) begin
                     phase_in      = gbrbe_pkg::PH_HALT;
                     res_valid     = 1'b1;
                     res_word.kind = gbrbe_pkg::KIND_HDRERR;
                  end else begin
                     phase_in  = gbrbe_pkg::PH_SEEK_ORIGIN;
                     column_in = 4'd0;
                     prefix_in = 1'b1;
                  end
               end else if (column_ff < gbrbe_pkg::HDR_LEN &&
                            b != gbrbe_pkg::hdr_char(column_ff[2:0])) begin
                  phase_in      = gbrbe_pkg::PH_HALT;
                  res_valid     = 1'b1;
                  res_word.kind = gbrbe_pkg::KIND_HDRERR;
               end else begin
                  column_in = column_inc;
                  if (column_inc >= gbrbe_pkg::NAME_COLUMN) begin
                     phase_in = gbrbe_pkg::PH_NAME;
                  end
               end
            end
            gbrbe_pkg::PH_NAME: begin
               if (b == gbrbe_pkg::CHAR_SPACE) begin
                  phase_in = gbrbe_pkg::PH_SKIPLINE;
               end else if (b == gbrbe_pkg::CHAR_LF) begin
                  phase_in  = gbrbe_pkg::PH_SEEK_ORIGIN;
                  column_in = 4'd0;
                  prefix_in = 1'b1;
               end else if (name_len_ff <
                            gbrbe_pkg::NAME_LEN_W'(gbrbe_pkg::NAME_LIMIT)) begin
                  name_len_in    = name_len_ff + gbrbe_pkg::NAME_LEN_W'(1);
                  res_valid      = 1'b1;
                  res_word.kind  = gbrbe_pkg::KIND_NAME;
                  res_word.value = b;
               end
            end
            gbrbe_pkg::PH_SKIPLINE: begin
               if (b == gbrbe_pkg::CHAR_LF) begin
                  phase_in  = gbrbe_pkg::PH_SEEK_ORIGIN;
                  column_in = 4'd0;
                  prefix_in = 1'b1;
               end
            end
            gbrbe_pkg::PH_SEEK_ORIGIN: begin
               if (b == gbrbe_pkg::CHAR_LF) begin
                  column_in = 4'd0;
                  prefix_in = 1'b1;
               end else if (column_ff < gbrbe_pkg::ORG_LEN) begin
                  if (b != gbrbe_pkg::org_char(column_ff[2:0])) begin
                     prefix_next = 1'b0;
                  end
                  prefix_in = prefix_next;
                  column_in = column_inc;
                  if (column_inc == gbrbe_pkg::ORG_LEN && prefix_next) begin
                     phase_in = gbrbe_pkg::PH_ORIGIN_LINE;
                  end
               end
            end
            gbrbe_pkg::PH_ORIGIN_LINE: begin
               if (b == gbrbe_pkg::CHAR_LF) begin
                  phase_in = gbrbe_pkg::PH_SEQ;
               end
            end
            gbrbe_pkg::PH_SEQ: begin
               if (b == gbrbe_pkg::CHAR_SLASH) begin
                  res_valid           = 1'b1;
                  res_word.kind       = gbrbe_pkg::KIND_DONE;
                  res_word.base_count = bases_ff;
                  phase_in            = gbrbe_pkg::PH_TRAILER;
                  column_in           = 4'd0;
                  prefix_in           = 1'b1;
                  name_len_in         = '0;
                  bases_in            = '0;
                  trailer_in          = 2'd2;
               end else if (code != gbrbe_pkg::NO_BASE) begin
                  // count with saturation, emit unless counting only
                  if (bases_ff != 32'hFFFF_FFFF) begin
                     bases_in = bases_ff + 32'd1;
                  end
                  if (!count_only) begin
                     res_valid      = 1'b1;
                     res_word.kind  = gbrbe_pkg::KIND_BASE;
                     res_word.value = code;
                  end
               end
            end
            gbrbe_pkg::PH_TRAILER: begin
               if (trailer_ff > 2'd1) begin
                  trailer_in = trailer_ff - 2'd1;
               end else begin
                  phase_in    = gbrbe_pkg::PH_HDR;
                  column_in   = 4'd0;
                  prefix_in   = 1'b1;
                  name_len_in = '0;
                  bases_in    = '0;
                  trailer_in  = 2'd0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Advance the parser state on each consumed word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= gbrbe_pkg::PH_HDR;
         column_ff   <= 4'd0;
         prefix_ff   <= 1'b1;
         name_len_ff <= '0;
         bases_ff    <= '0;
         trailer_ff  <= 2'd0;
      end else if (step) begin
         phase_ff    <= phase_in;
         column_ff   <= column_in;
         prefix_ff   <= prefix_in;
         name_len_ff <= name_len_in;
         bases_ff    <= bases_in;
         trailer_ff  <= trailer_in;
      end
   end

endmodule

// File: hdl/genbank_record_base_extractor.sv
// Top level of the GenBank record base extractor: input register, parser, result register.
//
// Usage: text bytes enter on the req_ channel, one word per byte, with
// end_of_text set on a word that marks the end of the input. Results leave on
// the rsp_ channel: record name bytes, base codes, record done with its base
// count, and end or error codes. A word is moved when valid is high and
// stall is low at a rising clock edge.
// A result leaves on rsp_ from the result register, which is loaded when its word
// steps out of the input register; words without a result are consumed silently.
// Throughput: one word per cycle while the receiver does not stall, set by the
// single parser step between the input register and the result register.
// The csr_ port sets count_only; write it only while the block is idle.
// When the receiver stalls, the result register holds and the input register
// holds one more word, after which req_stall rises.
// Reset (synchronous, active high) clears the valid flags of both registers,
// count_only and the parser, which then looks for a record header. After an
// error or an end code the block drops every word until reset.
`timescale 1ns / 1ps

module genbank_record_base_extractor (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  gbrbe_pkg::req_word_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output gbrbe_pkg::rsp_word_type rsp_data,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data
);

   logic                    in_valid_ff, in_valid_in;
   gbrbe_pkg::req_word_type in_word_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   gbrbe_pkg::rsp_word_type rsp_word_ff;
   logic                    count_only_ff;

   logic                    accept_in;
   logic                    advance;
   logic                    res_valid;
   gbrbe_pkg::rsp_word_type res_word;

   // Move a word through when the result register is free or being emptied
   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept_in   = req_valid && !req_stall;
   assign in_valid_in = accept_in || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? res_valid : (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   gbrbe_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .word       (in_word_ff),
      .count_only (count_only_ff),
      .res_valid  (res_valid),
      .res_word   (res_word)
   );

   // Hold the input word and its valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept_in) begin
         in_word_ff <= req_data;
      end
   end

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && res_valid) begin
         rsp_word_ff <= res_word;
      end
   end

   // Latch the count-only setting
   always_ff @(posedge clock) begin
      if (reset) begin
         count_only_ff <= 1'b0;
      end else if (csr_write_enable) begin
         count_only_ff <= csr_write_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_free_output_takes_input: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || !rsp_stall) |-> !req_stall)
      else $error("input stalled while result register free");

   a_base_code_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.kind == gbrbe_pkg::KIND_BASE) |->
      (rsp_word_ff.value <= 8'd3 || rsp_word_ff.value == gbrbe_pkg::AMBIG_CODE))
      else $error("bad base code");

   a_no_codes_when_counting: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.kind == gbrbe_pkg::KIND_BASE) |-> !count_only_ff)
      else $error("base code emitted in count-only mode");

   a_status_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.kind != gbrbe_pkg::KIND_NAME &&
       rsp_word_ff.kind != gbrbe_pkg::KIND_BASE) |-> rsp_word_ff.value == 8'd0)
      else $error("status word carries a value");
`endif

endmodule
